### rtl/fbpa_pkg.sv
package fbpa_pkg;

  // Widths of the stream payloads and the configuration port
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned APB_DATA_W  = 32;

  // Widths of the configuration registers
  localparam int unsigned ITEM_W  = 13;
  localparam int unsigned ALIGN_W = 3;
  localparam int unsigned COUNT_W = 9;

  // Stride and first-slot arithmetic widths
  localparam int unsigned STRIDE_W = 14;
  localparam int unsigned FIRST_W  = 33;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_MISALIGN = 2'd3;

  // Register indexes (word address bits of paddr)
  localparam logic [1:0] REG_CHUNK_BASE = 2'd0;
  localparam logic [1:0] REG_ITEM_SIZE  = 2'd1;
  localparam logic [1:0] REG_ALIGN_LOG2 = 2'd2;
  localparam logic [1:0] REG_SLOT_COUNT = 2'd3;

endpackage

### rtl/fixed_block_pool_allocator_top.sv
// Allocate: the head's successor is read from the link memory at the input transfer.
// Free and check: the restoring divider takes one address bit per cycle; a request that fails
// before the divide or an undefined operation goes straight to the result.
// Only one item is in flight; the next input transfer is taken once the result is registered.
// Reset is asynchronous and active low; afterwards, and after every register write, a sweep
// over all SLOTS entries rebuilds the free list in the link memory while no input is accepted.
module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
#(
  parameter int unsigned SLOTS     = 256,
  parameter int unsigned PTR_BYTES = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  // Request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [ADDR_W-1:0]      s_axis_tdata,  // [31:0] address
  input  logic [OP_W-1:0]        s_axis_tuser,  // [1:0] operation
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [31:0] slot_address, [32] ok, [34:33] status
);

  // Index width of the link memory and width of a link, which can also hold SLOTS itself
  // (the end of the list).
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned EW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int unsigned PW = LW + STRIDE_W;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_ARD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_LOC  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  // Configuration registers
  logic [ADDR_W-1:0]  chunk_base_q;
  logic [ITEM_W-1:0]  item_size_q;
  logic [ALIGN_W-1:0] align_log2_q;
  logic [COUNT_W-1:0] slot_count_q;

  // Derived geometry, registered so that it does not sit in front of the multiplier
  logic [STRIDE_W-1:0] stride_d, stride_q;
  logic [FIRST_W-1:0]  first_d, first_q;
  logic [LW-1:0]       eff_d, eff_q;

  // Control
  logic [2:0]    state_q, state_d;
  logic [IW-1:0] sweep_q;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] free_cnt_q, free_cnt_d;
  logic          m_valid_q;

  // Working registers of the current item
  logic [OP_W-1:0]     op_q;
  logic [PW-1:0]       prod_q;
  logic [ADDR_W-1:0]   dvd_q;
  logic [STRIDE_W-1:0] rem_q;
  logic [ADDR_W-1:0]   quo_q;
  logic [4:0]          bit_cnt_q;
  logic [ADDR_W-1:0]   res_addr_q;
  logic                res_ok_q;
  logic [STAT_W-1:0]   res_status_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // Link memory
  logic [LW-1:0] link_mem [SLOTS];
  logic [LW-1:0] mem_rdata_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic          mem_re;

  logic cfg_wr;
  logic in_xfer;
  logic out_free;
  logic pool_empty;
  logic addr_below;
  logic [STRIDE_W:0] div_trial;
  logic              div_ge;
  logic [7:0]        align_bytes;
  logic [STRIDE_W-1:0] rounded;
  logic [EW-1:0]     count_ext;

  assign pready        = 1'b1;
  assign cfg_wr        = psel & penable & pwrite & pready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The list counts as empty when nothing is on it or the head has run off the end.
  assign pool_empty = (free_cnt_q == '0) || (head_q >= LW'(SLOTS));
  assign addr_below = {1'b0, s_axis_tdata} < first_q;

  // One step of restoring division: bring down the next offset bit and try the stride.
  assign div_trial = {rem_q, dvd_q[ADDR_W-1]};
  assign div_ge    = div_trial >= {1'b0, stride_q};

  // Slot geometry from the configuration registers.
  always_comb begin
    align_bytes = 8'd1 << align_log2_q;
    rounded     = (STRIDE_W'(item_size_q) + STRIDE_W'(align_bytes) - STRIDE_W'(1))
                  & ~(STRIDE_W'(align_bytes) - STRIDE_W'(1));
    stride_d    = (rounded < STRIDE_W'(PTR_BYTES)) ? STRIDE_W'(PTR_BYTES) : rounded;
    first_d     = (FIRST_W'(chunk_base_q) + FIRST_W'(PTR_BYTES) + FIRST_W'(align_bytes)
                  - FIRST_W'(1)) & ~(FIRST_W'(align_bytes) - FIRST_W'(1));
    count_ext   = EW'(slot_count_q);
    eff_d       = (count_ext > EW'(SLOTS)) ? LW'(SLOTS) : LW'(count_ext);
  end

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      REG_CHUNK_BASE: prdata = chunk_base_q;
      REG_ITEM_SIZE:  prdata = APB_DATA_W'(item_size_q);
      REG_ALIGN_LOG2: prdata = APB_DATA_W'(align_log2_q);
      REG_SLOT_COUNT: prdata = APB_DATA_W'(slot_count_q);
      default:        prdata = '0;
    endcase
  end

  // Memory port selection: the rebuild sweep and an accepted free write, an allocate reads
  // the successor of the head.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_q;
    mem_wdata = LW'(sweep_q) + LW'(1);
    mem_re    = 1'b0;
    if (state_q == ST_INIT) begin
      mem_we = 1'b1;
    end else if (state_q == ST_LOC && op_q == OP_FREE &&
                 quo_q < ADDR_W'(eff_q) && rem_q == '0) begin
      mem_we    = 1'b1;
      mem_waddr = quo_q[IW-1:0];
      mem_wdata = head_q;
    end
    if (in_xfer && s_axis_tuser == OP_ALLOC && !pool_empty) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= link_mem[head_q[IW-1:0]];
    end
  end

  // Next state of the sequencer, the free-list head and the free count.
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    free_cnt_d = free_cnt_q;
    case (state_q)
      ST_INIT: begin
        if (sweep_q == IW'(SLOTS - 1)) begin
          state_d    = ST_IDLE;
          head_d     = '0;
          free_cnt_d = eff_q;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_axis_tuser)
            OP_ALLOC: state_d = pool_empty ? ST_FIN : ST_ARD;
            OP_FREE,
            OP_CHECK: state_d = addr_below ? ST_FIN : ST_DIV;
            default:  state_d = ST_FIN;
          endcase
        end
      end
      ST_ARD: begin
        head_d     = mem_rdata_q;
        free_cnt_d = free_cnt_q - LW'(1);
        state_d    = ST_FIN;
      end
      ST_DIV: begin
        if (bit_cnt_q == 5'd31) begin
          state_d = ST_LOC;
        end
      end
      ST_LOC: begin
        if (mem_we) begin
          head_d = LW'(quo_q);
          if (free_cnt_q < eff_q) begin
            free_cnt_d = free_cnt_q + LW'(1);
          end
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
    // A register write rebuilds the pool.
    if (cfg_wr) begin
      state_d = ST_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_base_q <= '0;
      item_size_q  <= ITEM_W'(8);
      align_log2_q <= ALIGN_W'(3);
      slot_count_q <= COUNT_W'(256);
      state_q      <= ST_INIT;
      sweep_q      <= '0;
      head_q       <= '0;
      free_cnt_q   <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_CHUNK_BASE: chunk_base_q <= pwdata;
          REG_ITEM_SIZE:  item_size_q  <= pwdata[ITEM_W-1:0];
          REG_ALIGN_LOG2: align_log2_q <= pwdata[ALIGN_W-1:0];
          REG_SLOT_COUNT: slot_count_q <= pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      state_q    <= state_d;
      head_q     <= head_d;
      free_cnt_q <= free_cnt_d;
      if (cfg_wr || state_q != ST_INIT) begin
        sweep_q <= '0;
      end else begin
        sweep_q <= sweep_q + IW'(1);
      end
      if (state_q == ST_FIN && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath of the current item: geometry, product, divider and result.
  always_ff @(posedge clk_i) begin
    stride_q <= stride_d;
    first_q  <= first_d;
    eff_q    <= eff_d;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_q         <= s_axis_tuser;
          prod_q       <= PW'(head_q) * PW'(stride_q);
          dvd_q        <= s_axis_tdata - first_q[ADDR_W-1:0];
          rem_q        <= '0;
          quo_q        <= '0;
          bit_cnt_q    <= '0;
          res_addr_q   <= '0;
          res_ok_q     <= 1'b0;
          res_status_q <= STAT_DONE;
          case (s_axis_tuser)
            OP_ALLOC: begin
              if (pool_empty) begin
                res_status_q <= STAT_EMPTY;
              end
            end
            OP_FREE,
            OP_CHECK: begin
              if (addr_below) begin
                res_status_q <= STAT_OUTSIDE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ARD: begin
        res_addr_q <= first_q[ADDR_W-1:0] + ADDR_W'(prod_q);
        res_ok_q   <= 1'b1;
      end
      ST_DIV: begin
        rem_q     <= div_ge ? STRIDE_W'(div_trial - {1'b0, stride_q})
                            : div_trial[STRIDE_W-1:0];
        dvd_q     <= {dvd_q[ADDR_W-2:0], 1'b0};
        quo_q     <= {quo_q[ADDR_W-2:0], div_ge};
        bit_cnt_q <= bit_cnt_q + 5'd1;
      end
      ST_LOC: begin
        if (quo_q >= ADDR_W'(eff_q)) begin
          res_status_q <= STAT_OUTSIDE;
        end else if (rem_q != '0) begin
          res_status_q <= STAT_MISALIGN;
        end else begin
          res_ok_q <= 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          m_data_q <= OUT_TDATA_W'({res_status_q, res_ok_q, res_addr_q});
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/fbpa_checker.sv
module fbpa_checker
  import fbpa_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A successful result always carries the done status.
  a_ok_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[34:33] == STAT_DONE)
    else $error("ok set with a failure status");

  // Any failure reports a zero slot address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34:33] != STAT_DONE |-> m_axis_tdata[31:0] == '0)
    else $error("failure with non-zero slot address");

  // Only one item is in flight: a request transfer closes the input.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted on consecutive cycles");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);
